### hw/rtl/assert_macros.svh
// Assertion macros used by the allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock, idle while reset is held.
`define FFBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Assert that one condition implies another in the next cycle.
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ffba_pkg.sv
// Package: types and constants of the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned IDX_OUT_W = 5;
  localparam int unsigned SIZE_IO_W = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC = 3'd0,
    ST_NOFIT = 3'd1,
    ST_FREED = 3'd2,
    ST_NONE  = 3'd3,
    ST_FULL  = 3'd4,
    ST_INIT  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_ALLOC = 2'd1,
    RES_FREED = 2'd2
  } res_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SPLIT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     do_init;
    logic     scan_clr;
    logic     scan_inc;
    logic     rd_scan;
    logic     rd_shift;
    logic     wr_shift;
    logic     wr_remain;
    logic     wr_req;
    logic     mark_alloc;
    logic     mark_free;
    logic     do_split;
    logic     set_res;
    res_sel_e res_sel;
    status_e  res_status;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic req_zero;
    logic scan_end;
    logic fit;
    logic exact;
    logic full;
    logic used;
    logic shift_more;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/ffba_datapath.sv
// Datapath: block table memory, free marks, counters, result and output registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffba_datapath #(
  parameter int unsigned MAX_BLOCKS = 32,
  parameter int unsigned SIZE_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [ffba_pkg::SIZE_IO_W-1:0]   pool_size_i,
  input  logic [ffba_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [ffba_pkg::SIZE_IO_W-1:0]   request_size_i,
  input  ffba_pkg::cmd_t                   cmd_i,
  output ffba_pkg::sts_t                   sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [ffba_pkg::STATUS_W-1:0]    status_o,
  output logic [ffba_pkg::IDX_OUT_W-1:0]   block_index_o,
  output logic [ffba_pkg::SIZE_IO_W-1:0]   block_size_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  logic [SIZE_WIDTH-1:0]            mem [MAX_BLOCKS];
  logic [SIZE_WIDTH-1:0]            rd_q;

  logic [ffba_pkg::SIZE_IO_W-1:0]   pool_q;
  ffba_pkg::op_e                    op_q;
  logic [SIZE_WIDTH-1:0]            req_q;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [MAX_BLOCKS-1:0]            marks_q, marks_d;
  logic [CNT_W-1:0]                 scan_q, scan_d;
  logic [CNT_W-1:0]                 ptr_q, ptr_d;
  logic [SIZE_WIDTH-1:0]            remain_q;
  ffba_pkg::status_e                res_status_q;
  logic [IDX_W-1:0]                 res_idx_q;
  logic [SIZE_WIDTH-1:0]            res_size_q;
  logic                             out_valid_q;
  logic [ffba_pkg::STATUS_W-1:0]    out_status_q;
  logic [ffba_pkg::IDX_OUT_W-1:0]   out_idx_q;
  logic [ffba_pkg::SIZE_IO_W-1:0]   out_size_q;

  logic [SIZE_WIDTH+ffba_pkg::SIZE_IO_W-1:0] req_ext, pool_ext;
  logic [IDX_W+ffba_pkg::IDX_OUT_W-1:0]      idx_ext;
  logic [SIZE_WIDTH+ffba_pkg::SIZE_IO_W-1:0] size_ext;
  logic [SIZE_WIDTH-1:0]            req_in, pool_sz;
  logic [CNT_W-1:0]                 scan_plus1, ptr_minus1;
  logic [IDX_W-1:0]                 scan_idx;
  logic [MAX_BLOCKS-1:0]            marks_up;
  logic                             mem_we, mem_re;
  logic [IDX_W-1:0]                 mem_waddr, mem_raddr;
  logic [SIZE_WIDTH-1:0]            mem_wdata;

  assign req_ext    = {{SIZE_WIDTH{1'b0}}, request_size_i};
  assign req_in     = req_ext[SIZE_WIDTH-1:0];
  assign pool_ext   = {{SIZE_WIDTH{1'b0}}, pool_q};
  assign pool_sz    = pool_ext[SIZE_WIDTH-1:0];
  assign scan_plus1 = scan_q + CNT_W'(1);
  assign ptr_minus1 = ptr_q - CNT_W'(1);
  assign scan_idx   = scan_q[IDX_W-1:0];
  assign marks_up   = {marks_q[MAX_BLOCKS-2:0], 1'b0};

  assign sts_o.op         = op_q;
  assign sts_o.req_zero   = (req_q == '0);
  assign sts_o.scan_end   = (scan_q >= cnt_q);
  assign sts_o.fit        = marks_q[scan_idx] && (rd_q >= req_q);
  assign sts_o.exact      = (rd_q == req_q);
  assign sts_o.full       = (cnt_q == CNT_W'(MAX_BLOCKS));
  assign sts_o.used       = !marks_q[scan_idx];
  assign sts_o.shift_more = (ptr_q > scan_plus1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = req_q;
    if (cmd_i.do_init) begin
      mem_we    = 1'b1;
      mem_wdata = pool_sz;
    end else if (cmd_i.wr_shift) begin
      mem_we    = 1'b1;
      mem_waddr = ptr_q[IDX_W-1:0];
      mem_wdata = rd_q;
    end else if (cmd_i.wr_remain) begin
      mem_we    = 1'b1;
      mem_waddr = scan_plus1[IDX_W-1:0];
      mem_wdata = remain_q;
    end else if (cmd_i.wr_req) begin
      mem_we    = 1'b1;
      mem_waddr = scan_idx;
    end
  end

  assign mem_re    = cmd_i.rd_scan || cmd_i.rd_shift;
  assign mem_raddr = cmd_i.rd_shift ? ptr_minus1[IDX_W-1:0] : scan_idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    marks_d = marks_q;
    if (cmd_i.do_init) begin
      marks_d    = '0;
      marks_d[0] = 1'b1;
    end else if (cmd_i.mark_alloc) begin
      marks_d[scan_idx] = 1'b0;
    end else if (cmd_i.mark_free) begin
      marks_d[scan_idx] = 1'b1;
    end else if (cmd_i.do_split) begin
      for (int k = 0; k < MAX_BLOCKS; k++) begin
        if (CNT_W'(k) == scan_q) begin
          marks_d[k] = 1'b0;
        end else if (CNT_W'(k) == scan_plus1) begin
          marks_d[k] = 1'b1;
        end else if (CNT_W'(k) > scan_plus1) begin
          marks_d[k] = marks_up[k];
        end
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.do_init) begin
      cnt_d = CNT_W'(1);
    end else if (cmd_i.do_split) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    scan_d = scan_q;
    if (cmd_i.scan_clr) begin
      scan_d = '0;
    end else if (cmd_i.scan_inc) begin
      scan_d = scan_plus1;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.do_split) begin
      ptr_d = cnt_q;
    end else if (cmd_i.wr_shift) begin
      ptr_d = ptr_minus1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q      <= '1;
      cnt_q       <= '0;
      marks_q     <= '0;
      scan_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pool_q <= pool_size_i;
      end
      cnt_q   <= cnt_d;
      marks_q <= marks_d;
      scan_q  <= scan_d;
      ptr_q   <= ptr_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= ffba_pkg::op_e'(opcode_i);
      req_q <= req_in;
    end
    if (cmd_i.do_split) begin
      remain_q <= rd_q - req_q;
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      unique case (cmd_i.res_sel)
        ffba_pkg::RES_ALLOC: begin
          res_idx_q  <= scan_idx;
          res_size_q <= req_q;
        end
        ffba_pkg::RES_FREED: begin
          res_idx_q  <= scan_idx;
          res_size_q <= rd_q;
        end
        default: begin
          res_idx_q  <= '0;
          res_size_q <= '0;
        end
      endcase
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_idx_q    <= idx_ext[ffba_pkg::IDX_OUT_W-1:0];
      out_size_q   <= size_ext[ffba_pkg::SIZE_IO_W-1:0];
    end
  end

  assign idx_ext  = {{ffba_pkg::IDX_OUT_W{1'b0}}, res_idx_q};
  assign size_ext = {{ffba_pkg::SIZE_IO_W{1'b0}}, res_size_q};

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign block_index_o = out_idx_q;
  assign block_size_o  = out_size_q;

  `FFBA_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_BLOCKS), "block count above table depth")
  `FFBA_ASSERT_NEXT(a_split_grows, cmd_i.do_split, cnt_q == $past(cnt_q) + CNT_W'(1), "split did not add a block")
  `FFBA_ASSERT(a_load_free, cmd_i.load_out |-> (!out_valid_q || out_ready_i), "output word overwritten")
  `FFBA_ASSERT(a_split_room, cmd_i.do_split |-> (cnt_q < CNT_W'(MAX_BLOCKS)), "split with full table")

endmodule

### hw/rtl/ffba_ctrl.sv
// Controller: state machine that sequences init, scan, shift and result for each word.
`timescale 1ns / 1ps

module ffba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ffba_pkg::sts_t sts_i,
  output ffba_pkg::cmd_t cmd_o
);

  ffba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ffba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ffba_pkg::S_DECODE;
        end
      end
      ffba_pkg::S_DECODE: begin
        unique case (sts_i.op)
          ffba_pkg::OP_INIT: begin
            cmd_o.do_init    = 1'b1;
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ffba_pkg::ST_INIT;
            state_d          = ffba_pkg::S_FINISH;
          end
          ffba_pkg::OP_ALLOC: begin
            if (sts_i.req_zero) begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = ffba_pkg::ST_INIT;
              state_d          = ffba_pkg::S_FINISH;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d        = ffba_pkg::S_READ;
            end
          end
          ffba_pkg::OP_FREE: begin
            cmd_o.scan_clr = 1'b1;
            state_d        = ffba_pkg::S_READ;
          end
          default: begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ffba_pkg::ST_INIT;
            state_d          = ffba_pkg::S_FINISH;
          end
        endcase
      end
      ffba_pkg::S_READ: begin
        if (sts_i.scan_end) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = (sts_i.op == ffba_pkg::OP_FREE) ? ffba_pkg::ST_NONE
                                                            : ffba_pkg::ST_NOFIT;
          state_d          = ffba_pkg::S_FINISH;
        end else begin
          cmd_o.rd_scan = 1'b1;
          state_d       = ffba_pkg::S_CHECK;
        end
      end
      ffba_pkg::S_CHECK: begin
        if (sts_i.op == ffba_pkg::OP_FREE) begin
          if (sts_i.used) begin
            cmd_o.mark_free  = 1'b1;
            cmd_o.set_res    = 1'b1;
            cmd_o.res_sel    = ffba_pkg::RES_FREED;
            cmd_o.res_status = ffba_pkg::ST_FREED;
            state_d          = ffba_pkg::S_FINISH;
          end else begin
            cmd_o.scan_inc = 1'b1;
            state_d        = ffba_pkg::S_READ;
          end
        end else if (sts_i.fit) begin
          if (sts_i.exact) begin
            cmd_o.mark_alloc = 1'b1;
            cmd_o.set_res    = 1'b1;
            cmd_o.res_sel    = ffba_pkg::RES_ALLOC;
            cmd_o.res_status = ffba_pkg::ST_ALLOC;
            state_d          = ffba_pkg::S_FINISH;
          end else if (sts_i.full) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ffba_pkg::ST_FULL;
            state_d          = ffba_pkg::S_FINISH;
          end else begin
            cmd_o.do_split = 1'b1;
            state_d        = ffba_pkg::S_SHIFT_RD;
          end
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = ffba_pkg::S_READ;
        end
      end
      ffba_pkg::S_SHIFT_RD: begin
        if (sts_i.shift_more) begin
          cmd_o.rd_shift = 1'b1;
          state_d        = ffba_pkg::S_SHIFT_WR;
        end else begin
          cmd_o.wr_remain = 1'b1;
          state_d         = ffba_pkg::S_SPLIT;
        end
      end
      ffba_pkg::S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = ffba_pkg::S_SHIFT_RD;
      end
      ffba_pkg::S_SPLIT: begin
        cmd_o.wr_req     = 1'b1;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_sel    = ffba_pkg::RES_ALLOC;
        cmd_o.res_status = ffba_pkg::ST_ALLOC;
        state_d          = ffba_pkg::S_FINISH;
      end
      ffba_pkg::S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ffba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/first_fit_block_allocator_unit.sv
// First-fit block allocator: a single-port block table scanned and shifted one entry
// at a time. One word is worked on at a time. Init, a zero request and an unused
// opcode skip the scan and go straight to the result. A scan visits each table entry
// with one memory read and one compare, plus an end check when nothing is found. A
// split moves each entry above the split point up with a read and a write, then does
// the two table writes for the remainder and the request. The result sits in an output
// register, so the next word is taken while it waits. That word then holds in its last
// state until the register is free. Free blocks are never merged.
`timescale 1ns / 1ps

module first_fit_block_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = 32,
  parameter int unsigned SIZE_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ffba_pkg::SIZE_IO_W-1:0]   pool_size_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ffba_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [ffba_pkg::SIZE_IO_W-1:0]   request_size_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ffba_pkg::STATUS_W-1:0]    status_o,
  output logic [ffba_pkg::IDX_OUT_W-1:0]   block_index_o,
  output logic [ffba_pkg::SIZE_IO_W-1:0]   block_size_o
);

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .pool_size_i    (pool_size_i),
    .opcode_i       (opcode_i),
    .request_size_i (request_size_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .block_index_o  (block_index_o),
    .block_size_o   (block_size_o)
  );

endmodule

### sim/first_fit_block_allocator_unit_tb.sv
// Self-checking testbench for the first-fit block allocator unit.
`timescale 1ns / 1ps

module first_fit_block_allocator_unit_tb;

  localparam int unsigned MAX_BLOCKS  = 32;
  localparam int unsigned SIZE_WIDTH  = 16;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned ITEM_TARGET = 2000;
  localparam int unsigned SIZE_IO_W   = ffba_pkg::SIZE_IO_W;
  localparam int unsigned IDX_OUT_W   = ffba_pkg::IDX_OUT_W;
  localparam int unsigned OPCODE_W    = ffba_pkg::OPCODE_W;
  localparam int unsigned STATUS_W    = ffba_pkg::STATUS_W;

  typedef struct {
    ffba_pkg::op_e        op;
    logic [SIZE_IO_W-1:0] size;
  } request_t;

  typedef struct packed {
    ffba_pkg::status_e     status;
    logic [IDX_OUT_W-1:0]  index;
    logic [SIZE_IO_W-1:0]  size;
  } alloc_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [SIZE_IO_W-1:0] pool_size_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [OPCODE_W-1:0]  opcode_i = '0;
  logic [SIZE_IO_W-1:0] request_size_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [IDX_OUT_W-1:0] block_index_o;
  logic [SIZE_IO_W-1:0] block_size_o;

  // predicted block table
  logic [SIZE_IO_W-1:0] tbl_size [MAX_BLOCKS];
  bit                   tbl_free [MAX_BLOCKS];
  int unsigned          tbl_count = 0;
  logic [SIZE_IO_W-1:0] pool_units = 16'hFFFF;

  request_t      request_q[$];
  alloc_result_t pending_results[$];
  request_t      next_req;
  alloc_result_t oldest;

  bit          send_idle_en = 1'b1;
  bit          recv_idle_en = 1'b1;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned requests_taken = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned status_hits [8] = '{default: 0};

  first_fit_block_allocator_unit #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .SIZE_WIDTH(SIZE_WIDTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .pool_size_i   (pool_size_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .request_size_i(request_size_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .block_index_o (block_index_o),
    .block_size_o  (block_size_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Updates the table for one word and returns the result it produces.
  function automatic alloc_result_t apply_request(ffba_pkg::op_e op,
                                                  logic [SIZE_IO_W-1:0] req);
    alloc_result_t res;
    bit            found;
    int            i;
    int            j;
    res   = '{status: ffba_pkg::ST_INIT, index: '0, size: '0};
    found = 1'b0;
    case (op)
      ffba_pkg::OP_INIT: begin
        tbl_size[0] = pool_units;
        tbl_free[0] = 1'b1;
        tbl_count   = 1;
      end
      ffba_pkg::OP_ALLOC: begin
        if (req != '0) begin
          res.status = ffba_pkg::ST_NOFIT;
          for (i = 0; i < int'(tbl_count) && !found; i++) begin
            if (tbl_free[i] && tbl_size[i] >= req) begin
              found = 1'b1;
              if (tbl_size[i] > req && tbl_count >= MAX_BLOCKS) begin
                res.status = ffba_pkg::ST_FULL;
              end else begin
                if (tbl_size[i] > req) begin
                  for (j = int'(tbl_count); j > i + 1; j--) begin
                    tbl_size[j] = tbl_size[j-1];
                    tbl_free[j] = tbl_free[j-1];
                  end
                  tbl_size[i+1] = tbl_size[i] - req;
                  tbl_free[i+1] = 1'b1;
                  tbl_count++;
                  tbl_size[i] = req;
                end
                tbl_free[i] = 1'b0;
                res = '{status: ffba_pkg::ST_ALLOC, index: IDX_OUT_W'(i), size: req};
              end
            end
          end
        end
      end
      ffba_pkg::OP_FREE: begin
        res.status = ffba_pkg::ST_NONE;
        for (i = 0; i < int'(tbl_count) && !found; i++) begin
          if (!tbl_free[i]) begin
            found       = 1'b1;
            tbl_free[i] = 1'b1;
            res = '{status: ffba_pkg::ST_FREED, index: IDX_OUT_W'(i),
                    size: tbl_size[i]};
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 12);
    return $urandom_range(40, 150);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic queue_item(input ffba_pkg::op_e op, input logic [SIZE_IO_W-1:0] size);
    request_t item;
    item.op   = op;
    item.size = size;
    request_q.push_back(item);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid_i || pending_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic set_pool(input logic [SIZE_IO_W-1:0] units);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    pool_size_i <= units;
    do @(posedge clk_i); while (!cfg_ready_o);
    pool_units = units;
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      opcode_i       <= '0;
      request_size_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pending_results.push_back(apply_request(ffba_pkg::op_e'(opcode_i),
                                                request_size_i));
        requests_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          next_req = request_q.pop_front();
          in_valid_i     <= 1'b1;
          opcode_i       <= next_req.op;
          request_size_i <= next_req.size;
          send_gap = send_idle_en ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result backpressure, with an occasional long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!recv_idle_en) begin
        out_ready_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        recv_gap = pick_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      status_hits[status_o]++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, status", 32'(status_o), '0);
      end else begin
        oldest = pending_results.pop_front();
        if (status_o !== oldest.status) report_mismatch("status", 32'(status_o),
                                                        32'(oldest.status));
        if (block_index_o !== oldest.index) report_mismatch("block_index",
                                                            32'(block_index_o),
                                                            32'(oldest.index));
        if (block_size_o !== oldest.size) report_mismatch("block_size",
                                                          32'(block_size_o),
                                                          32'(oldest.size));
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no handshake for %0d cycles", STALL_LIMIT);
    $display("first_fit_block_allocator_unit test failed");
    $finish;
  end

  initial begin
    int unsigned          phase;
    int unsigned          total;
    int unsigned          n;
    int unsigned          k;
    int unsigned          r;
    logic [SIZE_IO_W-1:0] units;
    logic [SIZE_IO_W-1:0] req;
    ffba_pkg::op_e        op;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table, then reset pool size
    queue_item(ffba_pkg::OP_ALLOC, 16'd5);
    queue_item(ffba_pkg::OP_FREE, 16'd0);
    queue_item(ffba_pkg::OP_NOP, 16'hFFFF);
    queue_item(ffba_pkg::OP_INIT, 16'd0);
    queue_item(ffba_pkg::OP_ALLOC, 16'd0);
    queue_item(ffba_pkg::OP_ALLOC, 16'hFFFF);
    queue_item(ffba_pkg::OP_ALLOC, 16'd1);
    queue_item(ffba_pkg::OP_FREE, 16'hFFFF);
    queue_item(ffba_pkg::OP_INIT, 16'hFFFF);
    queue_item(ffba_pkg::OP_ALLOC, 16'd1);
    queue_item(ffba_pkg::OP_ALLOC, 16'hFFFE);
    queue_item(ffba_pkg::OP_FREE, 16'd0);
    queue_item(ffba_pkg::OP_FREE, 16'd0);
    queue_item(ffba_pkg::OP_FREE, 16'd0);
    queue_item(ffba_pkg::OP_ALLOC, 16'd1);
    queue_item(ffba_pkg::OP_ALLOC, 16'h8000);
    queue_item(ffba_pkg::OP_NOP, 16'h0000);
    wait_drained();

    // zero-sized pool
    set_pool(16'd0);
    queue_item(ffba_pkg::OP_INIT, 16'd0);
    queue_item(ffba_pkg::OP_ALLOC, 16'd1);
    queue_item(ffba_pkg::OP_ALLOC, 16'd0);
    queue_item(ffba_pkg::OP_FREE, 16'd0);
    wait_drained();

    total = 21;
    phase = 0;
    while (total < ITEM_TARGET) begin
      case (phase % 4)
        0:       units = SIZE_IO_W'($urandom_range(130, 1000));
        1:       units = 16'hFFFF;
        2:       units = 16'd1;
        default: units = SIZE_IO_W'($urandom);
      endcase
      set_pool(units);
      send_idle_en = (phase % 3) != 2;
      recv_idle_en = (phase % 5) != 3;
      n = $urandom_range(80, 200);
      queue_item(ffba_pkg::OP_INIT, SIZE_IO_W'($urandom));
      for (k = 1; k < n; k++) begin
        r   = $urandom_range(0, 99);
        req = SIZE_IO_W'($urandom);
        if (r < 3) begin
          op = ffba_pkg::OP_INIT;
        end else if (r < 6) begin
          op = ffba_pkg::OP_NOP;
        end else if (r < 36) begin
          op = ffba_pkg::OP_FREE;
        end else begin
          op = ffba_pkg::OP_ALLOC;
          r  = $urandom_range(0, 99);
          if (r < 3) begin
            req = '0;
          end else if (r < 55) begin
            req = SIZE_IO_W'($urandom_range(1, 4));
          end else if (r < 85) begin
            req = SIZE_IO_W'($urandom_range(1, (units == '0) ? 1 : units));
          end
        end
        queue_item(op, req);
      end
      total += n;
      // receiver stalls while the sender keeps offering
      if (phase == 1 || phase == 6) hold_requests++;
      wait_drained();
      phase++;
    end

    repeat (200) @(posedge clk_i);
    $display("%0d requests and %0d results checked over %0d pool settings",
             requests_taken, results_seen, cfg_writes);
    $display("allocated %0d, no fit %0d, freed %0d, none to free %0d, full %0d, other %0d",
             status_hits[ffba_pkg::ST_ALLOC], status_hits[ffba_pkg::ST_NOFIT],
             status_hits[ffba_pkg::ST_FREED], status_hits[ffba_pkg::ST_NONE],
             status_hits[ffba_pkg::ST_FULL], status_hits[ffba_pkg::ST_INIT]);
    if (errors == 0) begin
      $display("first_fit_block_allocator_unit test passed");
    end else begin
      $display("first_fit_block_allocator_unit test failed");
    end
    $finish;
  end

endmodule
